// ===== sv/rsp_pkg.sv =====
// Shared types and constants of the request stream parser.
package rsp_pkg;

  // Error codes reported with each result byte.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_STAR   = 3'd1,
    ERR_NO_DOLLAR = 3'd2,
    ERR_NO_DIGITS = 3'd3,
    ERR_BAD_CRLF  = 3'd4,
    ERR_ZERO_ARGS = 3'd5,
    ERR_CNT_BIG   = 3'd6,
    ERR_LEN_BIG   = 3'd7
  } err_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_MAX_ARGS    = 8'd0;
  localparam logic [7:0] REG_MAX_ARG_LEN = 8'd1;

  // Protocol characters.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Width used to compare a grown decimal value against its limit.
  localparam int CMP_W = 36;

endpackage

// ===== sv/resp_request_stream_parser.sv =====
// Top level of the request stream parser: byte phase machine with input and result registers.
//
// The parser takes one request byte per clock cycle while the output is not stalled and
// returns exactly one result per byte; an accepted byte passes the input register and then
// the result register. Sustained throughput is one byte per cycle, set by the phase machine,
// which updates its state and its decimal accumulator for one byte each cycle; the result
// register lets a new byte enter while a finished result still waits on the output.
// Configuration registers max_args (index 0) and max_arg_len (index 1) are always ready
// and are meant to be written while no byte is in flight. After any error the parser
// drops bytes until the next '*'.
module resp_request_stream_parser import rsp_pkg::*; #(
  parameter int LEN_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Request byte stream.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // Per-byte results.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_payload,
  output logic [15:0] arg_index,
  output logic        arg_done,
  output logic        request_done,
  output logic [2:0]  error,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Counts never exceed 16 bits and lengths never exceed 32 bits.
  localparam int LenBits = (LEN_WIDTH < 32) ? LEN_WIDTH : 32;
  localparam int CntBits = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam int AccW    = (LenBits > CntBits) ? LenBits : CntBits;
  localparam logic [31:0] LenCap =
    (LEN_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LEN_WIDTH) - 64'd1);
  localparam logic [15:0] CntCap =
    (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_WIDTH) - 32'd1);

  typedef enum logic [3:0] {
    PH_STAR, PH_CNT, PH_CNT_LF, PH_DOLLAR, PH_LEN,
    PH_LEN_LF, PH_PAYLOAD, PH_PAY_CR, PH_PAY_LF, PH_RESYNC
  } phase_t;

  // Input register.
  logic               held;
  logic [7:0]         held_byte;
  logic               advance;

  // Parser state and configuration.
  phase_t             phase, phase_next;
  logic [AccW-1:0]    acc, acc_next;
  logic               digit_seen, digit_seen_next;
  logic [CntBits-1:0] args_total, args_total_next;
  logic [CntBits-1:0] current_arg, current_arg_next;
  logic [CntBits-1:0] arg_inc;
  logic [LenBits-1:0] bytes_left, bytes_left_next;
  logic [15:0]        max_args;
  logic [31:0]        max_arg_len;

  // Per-byte decode.
  logic               is_digit;
  logic [3:0]         digit;
  logic [15:0]        cnt_lim;
  logic [31:0]        len_lim;
  logic [31:0]        lim;
  logic [AccW-1:0]    acc_sum;
  logic               acc_over;
  err_t               err;
  logic               pay, adone, rdone;
  logic [15:0]        idx;

  // Handshake: the held byte moves to the result register when that register is free.
  assign advance   = held && (!out_valid || out_ready);
  assign in_ready  = !held || advance;
  assign cfg_ready = 1'b1;

  // Byte classification and active limit.
  assign is_digit = (held_byte >= CH_ZERO) && (held_byte <= CH_NINE);
  assign digit    = 4'(held_byte - CH_ZERO);
  assign cnt_lim  = (max_args < CntCap) ? max_args : CntCap;
  assign len_lim  = (max_arg_len < LenCap) ? max_arg_len : LenCap;
  assign lim      = (phase == PH_CNT) ? 32'(cnt_lim) : len_lim;
  assign arg_inc  = current_arg + 1'b1;

  rsp_dec_acc #(.ACC_W(AccW)) u_acc (
    .acc   (acc),
    .digit (digit),
    .limit (lim),
    .sum   (acc_sum),
    .over  (acc_over)
  );

  // Next state and result for the held byte.
  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    digit_seen_next  = digit_seen;
    args_total_next  = args_total;
    current_arg_next = current_arg;
    bytes_left_next  = bytes_left;
    err              = ERR_NONE;
    pay              = 1'b0;
    adone            = 1'b0;
    rdone            = 1'b0;
    idx              = 16'd0;
    if (phase == PH_DOLLAR || phase == PH_LEN || phase == PH_LEN_LF ||
        phase == PH_PAYLOAD || phase == PH_PAY_CR || phase == PH_PAY_LF) begin
      idx = 16'(current_arg);
    end
    case (phase)
      PH_STAR, PH_RESYNC: begin
        if (held_byte == CH_STAR) begin
          acc_next        = '0;
          digit_seen_next = 1'b0;
          phase_next      = PH_CNT;
        end else if (phase == PH_STAR) begin
          err = ERR_NO_STAR;
        end
      end
      PH_CNT: begin
        if (is_digit) begin
          if (acc_over) begin
            err = ERR_CNT_BIG;
          end else begin
            acc_next        = acc_sum;
            digit_seen_next = 1'b1;
          end
        end else if (!digit_seen) begin
          err = ERR_NO_DIGITS;
        end else if (held_byte == CH_CR) begin
          phase_next = PH_CNT_LF;
        end else begin
          err = ERR_BAD_CRLF;
        end
      end
      PH_CNT_LF: begin
        if (held_byte != CH_LF) begin
          err = ERR_BAD_CRLF;
        end else if (acc == '0) begin
          err = ERR_ZERO_ARGS;
        end else begin
          args_total_next  = CntBits'(acc);
          current_arg_next = '0;
          phase_next       = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (held_byte == CH_DOLLAR) begin
          acc_next        = '0;
          digit_seen_next = 1'b0;
          phase_next      = PH_LEN;
        end else begin
          err = ERR_NO_DOLLAR;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          if (acc_over) begin
            err = ERR_LEN_BIG;
          end else begin
            acc_next        = acc_sum;
            digit_seen_next = 1'b1;
          end
        end else if (!digit_seen) begin
          err = ERR_NO_DIGITS;
        end else if (held_byte == CH_CR) begin
          phase_next = PH_LEN_LF;
        end else begin
          err = ERR_BAD_CRLF;
        end
      end
      PH_LEN_LF: begin
        if (held_byte != CH_LF) begin
          err = ERR_BAD_CRLF;
        end else begin
          bytes_left_next = LenBits'(acc);
          phase_next      = (acc == '0) ? PH_PAY_CR : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pay = 1'b1;
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - 1'b1;
        end
        if (bytes_left <= LenBits'(1)) begin
          phase_next = PH_PAY_CR;
        end
      end
      PH_PAY_CR: begin
        if (held_byte == CH_CR) begin
          phase_next = PH_PAY_LF;
        end else begin
          err = ERR_BAD_CRLF;
        end
      end
      PH_PAY_LF: begin
        if (held_byte != CH_LF) begin
          err = ERR_BAD_CRLF;
        end else begin
          adone            = 1'b1;
          current_arg_next = arg_inc;
          if (arg_inc >= args_total) begin
            rdone      = 1'b1;
            phase_next = PH_STAR;
          end else begin
            phase_next = PH_DOLLAR;
          end
        end
      end
      default: begin
        phase_next = PH_RESYNC;
      end
    endcase
    // Any error drops the parser into resync until the next '*'.
    if (err != ERR_NONE) begin
      phase_next = PH_RESYNC;
    end
  end

  // State, input register, result register and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_STAR;
      acc         <= '0;
      digit_seen  <= 1'b0;
      args_total  <= '0;
      current_arg <= '0;
      bytes_left  <= '0;
      max_args    <= 16'hFFFF;
      max_arg_len <= 32'hFFFF_FFFF;
    end else begin
      if (in_valid && in_ready) begin
        held      <= 1'b1;
        held_byte <= in_byte;
      end else if (advance) begin
        held <= 1'b0;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        out_byte     <= held_byte;
        is_payload   <= pay;
        arg_index    <= idx;
        arg_done     <= adone;
        request_done <= rdone;
        error        <= err;
        phase        <= phase_next;
        acc          <= acc_next;
        digit_seen   <= digit_seen_next;
        args_total   <= args_total_next;
        current_arg  <= current_arg_next;
        bytes_left   <= bytes_left_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_ARGS) begin
          max_args <= cfg_data[15:0];
        end else if (cfg_index == REG_MAX_ARG_LEN) begin
          max_arg_len <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== sv/rsp_dec_acc.sv =====
// Decimal accumulator step: value times ten plus one digit, checked against a limit.
module rsp_dec_acc import rsp_pkg::*; #(
  parameter int ACC_W = 32
) (
  input  logic [ACC_W-1:0] acc,
  input  logic [3:0]       digit,
  input  logic [31:0]      limit,
  output logic [ACC_W-1:0] sum,
  output logic             over
);

  localparam int SUM_W = ACC_W + 4;

  logic [SUM_W-1:0] acc_ext;
  logic [SUM_W-1:0] grown;

  // Times ten is a shift-and-add; the four extra bits hold any growth.
  assign acc_ext = SUM_W'(acc);
  assign grown   = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);

  // Growth past the limit is refused, except that from zero a single digit larger than
  // a limit below nine is still taken. A kept value stays within the limit or below ten,
  // so it fits ACC_W bits.
  assign over = (CMP_W'(grown) > CMP_W'(limit)) &&
                !((acc == '0) && (CMP_W'(digit) > CMP_W'(limit)));
  assign sum  = grown[ACC_W-1:0];

endmodule

// ===== sv/rsp_checker.sv =====
// Port-level checks of the request stream parser and their binding to the top level.
module rsp_checker import rsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        is_payload,
  input logic        arg_done,
  input logic        request_done,
  input logic [2:0]  error
);

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(error)))
    else $error("stalled result changed");

  // A request only closes together with its last argument.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && request_done) |-> arg_done)
    else $error("request closed without an argument closing");

  // An argument closes only on a line feed.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_done) |-> (out_byte == CH_LF))
    else $error("argument closed on a byte other than LF");

  // An error byte is never payload and never closes anything.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error != ERR_NONE) |-> (!is_payload && !arg_done && !request_done))
    else $error("error byte flagged as payload or closing");

  // Payload bytes never close an argument.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_payload) |-> !arg_done)
    else $error("payload byte closed an argument");

endmodule

bind resp_request_stream_parser rsp_checker u_rsp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .is_payload   (is_payload),
  .arg_done     (arg_done),
  .request_done (request_done),
  .error        (error)
);
